>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers. They compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// Types, constants and helpers shared by the binarize/pack block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BIT   = 2'd2;

    // sample modes
    localparam logic [1:0] MODE_U8  = 2'd0;
    localparam logic [1:0] MODE_S8  = 2'd1;

    localparam logic [1:0]  SAMPLE_MODE_RST = MODE_U8;
    localparam logic [15:0] THRESHOLD_RST   = 16'd128;
    localparam logic [2:0]  START_BIT_RST   = 3'd0;

    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef struct packed {
        logic [15:0] pixel;
        logic [7:0]  merge_byte;
        logic        last_pixel;
    } t_in_word;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  sample_mode;
        logic [15:0] threshold;
        logic [2:0]  start_bit_offset;
    } t_cfg;

    typedef struct packed {
        logic emit;
        logic run_active;
    } t_core_stat;

    // Maps raw bits to an unsigned key whose order matches the selected compare.
    function automatic logic [15:0] order_key(input logic [15:0] raw,
                                              input logic [1:0]  mode);
        logic [15:0] key;
        case (mode)
            MODE_U8: key = {8'h00, raw[7:0]};
            MODE_S8: key = {8'h00, ~raw[7], raw[6:0]};
            default: key = {~raw[15], raw[14:0]};
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// tbp_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [tbp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire [tbp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output tbp_pkg::t_cfg                    o_cfg
);
    import tbp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_MODE: n_cfg.sample_mode      = i_cfg_wdata[1:0];
                CFG_THRESHOLD:   n_cfg.threshold        = i_cfg_wdata[15:0];
                CFG_START_BIT:   n_cfg.start_bit_offset = i_cfg_wdata[2:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_mode      <= SAMPLE_MODE_RST;
            r_cfg.threshold        <= THRESHOLD_RST;
            r_cfg.start_bit_offset <= START_BIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/tbp_core.sv
// ----------------------------------------------------------------------------
// tbp_core
// Threshold compare and MSB-first bit packing with merge of old bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  tbp_pkg::t_in_word     i_word,
    input  tbp_pkg::t_cfg         i_cfg,
    output tbp_pkg::t_out_word    o_word,
    output tbp_pkg::t_core_stat   o_stat
);
    import tbp_pkg::*;

    logic [2:0] r_bit_pos;
    logic [7:0] r_acc;
    logic       r_run_started;

    logic [2:0] pos_eff;
    logic [7:0] acc_base;
    logic [7:0] mask;
    logic [7:0] acc_new;
    logic       hit;
    logic       emit;

    always_comb begin
        pos_eff  = r_run_started ? r_bit_pos : i_cfg.start_bit_offset;
        // a new byte starts from the destination's old contents
        acc_base = (!r_run_started || r_bit_pos == 3'd0) ? i_word.merge_byte : r_acc;
        hit      = order_key(i_word.pixel, i_cfg.sample_mode) >
                   order_key(i_cfg.threshold, i_cfg.sample_mode);
        mask     = MSB_MASK >> pos_eff;
        acc_new  = hit ? (acc_base | mask) : (acc_base & ~mask);
        emit     = (pos_eff == 3'd7) || i_word.last_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pos     <= 3'd0;
            r_acc         <= 8'h00;
            r_run_started <= 1'b0;
        end else if (i_step) begin
            r_acc <= acc_new;
            if (emit) begin
                r_bit_pos     <= 3'd0;
                r_run_started <= !i_word.last_pixel;
            end else begin
                r_bit_pos     <= pos_eff + 3'd1;
                r_run_started <= 1'b1;
            end
        end
    end

    assign o_word.packed_byte = acc_new;
    assign o_word.last_byte   = i_word.last_pixel;
    assign o_stat.emit        = emit;
    assign o_stat.run_active  = r_run_started;

endmodule

`default_nettype wire

>>> hw/rtl/threshold_binarize_pack.sv
// ----------------------------------------------------------------------------
// threshold_binarize_pack
// Grey pixel to 1 bpp binarizer with MSB-first byte packing.
//
// Input channel: one pixel word (pixel, merge_byte, last_pixel) per accepted
// i_in_valid && !o_in_stall. Output channel: one packed byte word, with
// last_byte marking the end of a run, per accepted o_out_valid && !i_out_stall.
// A byte leaves when its bit 0 is written or on the last pixel of a run.
// An accepted word is held in the input register and its byte, if any, is
// offered from the output register. Throughput: one pixel per cycle unless
// o_in_stall holds the input register; the compare, mask and merge sit in
// one stage between the input register and the output register.
// Reset: synchronous, active low; config returns to mode 0, threshold 128,
// start offset 0, and the next pixel begins a new run.
// Output stall: the output register holds its word; pixels that complete no
// byte still drain, otherwise o_in_stall rises once the input register is full.
// Config writes are meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module threshold_binarize_pack (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [tbp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [tbp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  tbp_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output tbp_pkg::t_out_word              o_out_word
);
    import tbp_pkg::*;

    t_cfg       cfg;
    t_core_stat core_stat;
    t_out_word  core_word;

    logic       r_in_valid;
    t_in_word   r_in_word;
    logic       r_out_valid;
    t_out_word  r_out_word;

    logic       out_free;
    logic       advance;
    logic       in_take;

    tbp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tbp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_word  (r_in_word),
        .i_cfg   (cfg),
        .o_word  (core_word),
        .o_stat  (core_stat)
    );

    // a pixel that completes no byte never needs the output register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (out_free || !core_stat.emit);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !advance);
            r_out_valid <= (advance && core_stat.emit) || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (advance && core_stat.emit) begin
            r_out_word <= core_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `TBP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n,
        r_out_valid && i_out_stall, !(advance && core_stat.emit),
        "stalled output word overwritten")
    `TBP_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n,
        advance && core_stat.emit, r_out_valid,
        "emitted word not presented")
    `TBP_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n,
        advance && r_in_word.last_pixel, !core_stat.run_active && r_out_word.last_byte,
        "run did not close on last pixel")

endmodule

`default_nettype wire
